// ===== rtl/core/dnle_pkg.sv =====
// shared types and constants of the dns name label encoder
package dnle_pkg;

    // label and name limits
    localparam int MAX_LABEL = 63;
    localparam int MAX_NAME  = 254;

    // derived widths
    localparam int LBL_W     = $clog2(MAX_LABEL + 1);
    localparam int NAME_W    = $clog2(MAX_NAME + 1);
    localparam int MEM_AW    = LBL_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int ERR_W     = 2;

    // job queue depth, a power of two
    localparam int Q_DEPTH   = 2;
    localparam int QP_W      = $clog2(Q_DEPTH);
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LABEL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NAME  = 2'd2;

    // one closed label waiting to be sent
    typedef struct packed {
        logic             bank;
        logic [LBL_W-1:0] cnt;
        logic [ERR_W-1:0] err;
        logic             fin;
    } t_job;

    // character write into the label buffer
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // buffer bank released by the back end
    typedef struct packed {
        logic en;
        logic bank;
    } t_done;

endpackage

// ===== rtl/core/dnle_front.sv =====
// front end: accepts characters, tracks label and name limits, closes labels
module dnle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_ch,
    input  logic            i_is_end,
    output dnle_pkg::t_wr   o_wr,
    output logic            o_push,
    output dnle_pkg::t_job  o_job,
    input  dnle_pkg::t_done i_done
);
    import dnle_pkg::*;

    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;
    logic [LBL_W-1:0]  r_lbl_cnt, n_lbl_cnt;
    logic [NAME_W-1:0] r_name_cnt, n_name_cnt;
    logic              r_seen, n_seen;
    logic [ERR_W-1:0]  r_err, n_err;
    logic              acc;

    // stall while the bank being filled is still being sent
    assign o_ready = !r_busy[r_bank];
    assign acc     = i_valid && o_ready;

    // classify the item and update label state
    always_comb begin
        n_bank     = r_bank;
        n_busy     = r_busy;
        n_lbl_cnt  = r_lbl_cnt;
        n_name_cnt = r_name_cnt;
        n_seen     = r_seen;
        n_err      = r_err;
        o_push     = 1'b0;
        o_job      = '{bank: r_bank, cnt: r_lbl_cnt, err: r_err, fin: i_is_end};
        o_wr       = '{en: 1'b0, addr: {r_bank, r_lbl_cnt}, data: i_ch};

        if (i_done.en) begin
            n_busy[i_done.bank] = 1'b0;
        end

        if (acc) begin
            if (i_is_end) begin
                if (r_seen) begin
                    o_push         = 1'b1;
                    n_busy[r_bank] = 1'b1;
                    n_bank         = !r_bank;
                end
                n_lbl_cnt  = '0;
                n_name_cnt = '0;
                n_seen     = 1'b0;
                n_err      = ERR_OK;
            end else begin
                n_seen = 1'b1;
                if (r_name_cnt >= NAME_W'(MAX_NAME)) begin
                    // name full: drop everything, dots too
                    n_err = ERR_NAME;
                end else begin
                    n_name_cnt = r_name_cnt + {{(NAME_W-1){1'b0}}, 1'b1};
                    if (i_ch == DOT_CHAR) begin
                        o_push         = 1'b1;
                        n_busy[r_bank] = 1'b1;
                        n_bank         = !r_bank;
                        n_lbl_cnt      = '0;
                        if (r_err == ERR_LABEL) begin
                            n_err = ERR_OK;
                        end
                    end else if (r_lbl_cnt >= LBL_W'(MAX_LABEL)) begin
                        // label full: drop the character
                        if (r_err != ERR_NAME) begin
                            n_err = ERR_LABEL;
                        end
                    end else begin
                        o_wr.en   = 1'b1;
                        n_lbl_cnt = r_lbl_cnt + {{(LBL_W-1){1'b0}}, 1'b1};
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank     <= 1'b0;
            r_busy     <= '0;
            r_lbl_cnt  <= '0;
            r_name_cnt <= '0;
            r_seen     <= 1'b0;
            r_err      <= ERR_OK;
        end else begin
            r_bank     <= n_bank;
            r_busy     <= n_busy;
            r_lbl_cnt  <= n_lbl_cnt;
            r_name_cnt <= n_name_cnt;
            r_seen     <= n_seen;
            r_err      <= n_err;
        end
    end

    // a label is never closed into a bank that is still being sent
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !r_busy[r_bank])
        else $error("label closed into busy bank");

    // only a bank in use is released
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done.en |-> r_busy[i_done.bank])
        else $error("release of idle bank");

    // end marker returns name state to reset values
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_is_end) |=> (r_name_cnt == '0 && !r_seen && r_lbl_cnt == '0
                               && r_err == ERR_OK))
        else $error("name state not cleared at end");

endmodule

// ===== rtl/core/dnle_queue.sv =====
// short job queue between front and back end
module dnle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dnle_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_nempty,
    output dnle_pkg::t_job o_head
);
    import dnle_pkg::*;

    t_job            r_q [0:Q_DEPTH-1];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            full;

    assign o_nempty = (r_cnt != '0);
    assign full     = (r_cnt == QC_W'(Q_DEPTH));
    assign o_head   = r_q[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + {{(QP_W-1){1'b0}}, 1'b1};
            end
            if (i_pop) begin
                r_rp <= r_rp + {{(QP_W-1){1'b0}}, 1'b1};
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + {{(QC_W-1){1'b0}}, 1'b1};
                2'b01:   r_cnt <= r_cnt - {{(QC_W-1){1'b0}}, 1'b1};
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("job queue underflow");

endmodule

// ===== rtl/core/dnle_back.sv =====
// back end: label buffer and byte emitter with output register
module dnle_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dnle_pkg::t_wr   i_wr,
    input  logic            i_q_nempty,
    input  dnle_pkg::t_job  i_q_head,
    output logic            o_pop,
    output dnle_pkg::t_done o_done,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_is_length,
    output logic            o_last,
    output logic [1:0]      o_error
);
    import dnle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LEN  = 3'b010,
        S_DATA = 3'b100
    } t_state;

    logic [7:0]        mem [0:MEM_DEPTH-1];
    logic [7:0]        r_rd_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [LBL_W-1:0]  r_idx, n_idx;
    logic [LBL_W-1:0]  idx_nxt;
    logic              slot_free;
    logic              load;
    logic [7:0]        ld_byte;
    logic              ld_len;
    logic              ld_last;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_len;
    logic              r_out_last;
    logic [ERR_W-1:0]  r_out_err;

    assign slot_free = !r_out_valid || i_ready;
    assign idx_nxt   = r_idx + {{(LBL_W-1){1'b0}}, 1'b1};

    // label buffer, two banks, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // emitter sequencing
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        o_done  = '{en: 1'b0, bank: r_job.bank};
        rd_en   = 1'b0;
        rd_addr = {r_job.bank, {LBL_W{1'b0}}};
        load    = 1'b0;
        ld_byte = r_rd_data;
        ld_len  = 1'b0;
        ld_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_nempty) begin
                    o_pop   = 1'b1;
                    n_job   = i_q_head;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = {{(8-LBL_W){1'b0}}, r_job.cnt};
                    ld_len  = 1'b1;
                    ld_last = r_job.fin && (r_job.cnt == '0);
                    if (r_job.cnt == '0) begin
                        o_done.en = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        n_idx   = '0;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_last = r_job.fin && (idx_nxt == r_job.cnt);
                    if (idx_nxt == r_job.cnt) begin
                        o_done.en = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {r_job.bank, idx_nxt};
                        n_idx   = idx_nxt;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job <= n_job;
        r_idx <= n_idx;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_len  <= ld_len;
            r_out_last <= ld_last;
            r_out_err  <= r_job.err;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_length = r_out_len;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    // reads stay inside the closed label
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_idx < r_job.cnt))
        else $error("label read past its length");

    // bank is released only together with the load of the label's final byte
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.en |-> load)
        else $error("bank released without final byte");

endmodule

// ===== rtl/core/dns_name_label_encoder_core.sv =====
// top level of the dns name label encoder
//
// Input channel i_valid/o_ready carries one name character per transfer
// (i_ch), or an end marker (i_is_end = 1) that closes the name. A dot or the
// end marker closes the open label; the output channel o_valid/i_ready then
// carries its length byte (o_is_length = 1) followed by its characters.
// o_last marks the final byte of the name, o_error carries the truncation
// code of the label (label over 63 characters, name over 254 characters).
// The root zero byte is not produced; an empty name produces nothing.
//
// Characters are taken at one per cycle, while the bank to be filled is
// free, into one of two label buffer banks. A closed label waits in a
// two-entry job queue; the emitter then picks up the job and sends one byte
// per cycle, while the receiver is ready, from the registered buffer read.
// Input stalls when the bank to be filled is still being sent, so the two
// banks set the sustained rate. Reset clears the control state but for the
// emitter's job and index registers; the buffer needs no clearing. A stalled
// receiver holds the output register and the emitter, and backs up into the
// input through the bank busy flags.
module dns_name_label_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_length,
    output logic       o_last,
    output logic [1:0] o_error
);
    import dnle_pkg::*;

    t_wr   wr;
    t_job  push_job;
    t_job  q_head;
    t_done done;
    logic  push;
    logic  pop;
    logic  q_nempty;

    // accept and classify
    dnle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_ch     (i_ch),
        .i_is_end (i_is_end),
        .o_wr     (wr),
        .o_push   (push),
        .o_job    (push_job),
        .i_done   (done)
    );

    // closed labels waiting to be sent
    dnle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_head   (q_head)
    );

    // send length byte and characters
    dnle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_q_nempty  (q_nempty),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_done      (done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_is_length (o_is_length),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule
